[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the k-of-n window qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define KWL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check on clk_i, active during reset as well.
`define KWL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/kwl_pkg.sv]
// Types and constants of the k-of-n window qualifier.
`default_nettype none

package kwl_pkg;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_WINDOW_FRAMES   = 2'd0,
    CFG_REQUIRED_FRAMES = 2'd1,
    CFG_TIMEOUT_MS      = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] OUTCOME_GREEN     = 2'd0;
  localparam logic [1:0] OUTCOME_NOT_GREEN = 2'd1;
  localparam logic [1:0] OUTCOME_UNUSABLE  = 2'd2;

  localparam logic [5:0]  WINDOW_FRAMES_RST   = 6'd5;
  localparam logic [5:0]  REQUIRED_FRAMES_RST = 6'd3;
  localparam logic [31:0] TIMEOUT_MS_RST      = 32'd1000;

  // Control from the top level into the window unit.
  typedef struct packed {
    logic step;   // one word is processed this cycle
    logic frame;  // word is a frame verdict
    logic green;  // verdict is green
    logic clear;  // timeout: empty the window
  } win_ctrl_t;

endpackage

`default_nettype wire

[sv/k_of_n_window_latch_with_timeout_core.sv]
// k-of-n sliding-window start qualifier with camera timeout, top level.
// Input stream (s_axis): one word per frame verdict or time tick. tuser is the
// opcode (frame or tick); tdata carries outcome and now_ms.
// Output stream (m_axis): exactly one word per input word, the state after
// the update: start_permitted, camera_active and green_count.
// Configuration: cfg_we_i writes window_frames, required_frames or timeout_ms
// at cfg_idx_i; write only while no word is in flight.
// Path: an accepted word sits in the input register, then its result goes to the
// result register. Throughput: one word per cycle while the receiver takes results;
// the window shift, the green count update and the 32-bit age compare are combinational.
// Reset (rst_ni low, asynchronous) empties the window, clears the latch and
// liveness, and restores the register defaults 5, 3 and 1000 ms.
// When the receiver stalls, the result register holds its word and the input
// register takes one more word; s_axis_tready falls only when both are full.
`default_nettype none

`include "assert_macros.svh"

module k_of_n_window_latch_with_timeout_core #(
  parameter int unsigned MAX_WINDOW = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [1:0] outcome, [33:2] now_ms, [39:34] zero
  input  wire logic [0:0]  s_axis_tuser,  // [0] opcode
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [0] start_permitted, [1] camera_active,
                                          // [7:2] green_count
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import kwl_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);

  logic [5:0]  window_frames_q, required_frames_q;
  logic [31:0] timeout_q;

  logic        in_vld_q, in_vld_d;
  op_e         in_op_q;
  logic [1:0]  in_outcome_q;
  logic [31:0] in_now_q;

  logic        out_vld_q, out_vld_d;
  logic [7:0]  out_data_q;

  logic        accept_in, advance, step, usable, clr, alive_d, latched_q, latched_d;
  logic [5:0]  green_d;
  logic [CW-1:0] hit_q;
  win_ctrl_t   win_ctrl;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_frames_q   <= WINDOW_FRAMES_RST;
      required_frames_q <= REQUIRED_FRAMES_RST;
      timeout_q         <= TIMEOUT_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_FRAMES:   window_frames_q   <= cfg_data_i[5:0];
        CFG_REQUIRED_FRAMES: required_frames_q <= cfg_data_i[5:0];
        CFG_TIMEOUT_MS:      timeout_q         <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // handshake: the result register frees the input register
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign step          = in_vld_q && advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept_in) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_op_q      <= op_e'(s_axis_tuser[0]);
      in_outcome_q <= s_axis_tdata[1:0];
      in_now_q     <= s_axis_tdata[33:2];
    end
  end

  // outcome codes two and three count as unusable
  assign usable = (in_outcome_q == OUTCOME_GREEN) || (in_outcome_q == OUTCOME_NOT_GREEN);

  kwl_live u_live (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .op_i      (in_op_q),
    .usable_i  (usable),
    .now_i     (in_now_q),
    .latched_i (latched_q),
    .timeout_i (timeout_q),
    .alive_d_o (alive_d),
    .clear_o   (clr)
  );

  always_comb begin
    win_ctrl.step  = step;
    win_ctrl.frame = (in_op_q == OP_FRAME);
    win_ctrl.green = (in_outcome_q == OUTCOME_GREEN);
    win_ctrl.clear = clr;
  end

  kwl_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (win_ctrl),
    .window_frames_i   (window_frames_q),
    .required_frames_i (required_frames_q),
    .hit_q_o           (hit_q),
    .green_d_o         (green_d),
    .latched_q_o       (latched_q),
    .latched_d_o       (latched_d)
  );

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {green_d, alive_d, latched_d};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  `KWL_ASSERT(a_latch_sticky, latched_q |=> latched_q,
              "start latch dropped without reset")
  `KWL_ASSERT(a_ready_low_only_full,
              !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready),
              "input stalled while a stage was free")
  `KWL_ASSERT(a_timeout_empties, (step && clr) |=> (hit_q == '0),
              "window not emptied after timeout")
  `KWL_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (!in_vld_q && !out_vld_q && !latched_q),
                     "state not cleared in reset")

endmodule

`default_nettype wire

[sv/kwl_window.sv]
// Sliding verdict window: shift register, fill count, green count and start latch.
`default_nettype none

module kwl_window #(
  parameter int unsigned MAX_WINDOW = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kwl_pkg::win_ctrl_t ctrl_i,
  input  wire logic [5:0]        window_frames_i,
  input  wire logic [5:0]        required_frames_i,
  output logic [$clog2(MAX_WINDOW+1)-1:0] hit_q_o,
  output logic [5:0]             green_d_o,
  output logic                   latched_q_o,
  output logic                   latched_d_o
);
  import kwl_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WW = (CW > 6) ? CW : 6;
  localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [MAX_WINDOW-1:0] bits_q, bits_d, bits_ev;
  logic [CW-1:0]         fill_q, fill_d, fill_m1;
  logic [CW-1:0]         hit_q, hit_d, hit_ev;
  logic                  latched_q, latched_d;
  logic [WW-1:0]         eff_win, wf_ext;
  logic                  push, evict, old_bit;
  logic [IW-1:0]         old_idx;

  always_comb begin
    wf_ext = WW'(window_frames_i);
    if (wf_ext == '0) begin
      eff_win = WW'(1);
    end else if (wf_ext > WW'(MAX_WINDOW)) begin
      eff_win = WW'(MAX_WINDOW);
    end else begin
      eff_win = wf_ext;
    end
  end

  assign push    = ctrl_i.step && ctrl_i.frame && !latched_q;
  assign evict   = (WW'(fill_q) >= eff_win);
  assign fill_m1 = fill_q - CW'(1);
  assign old_idx = fill_m1[IW-1:0];
  assign old_bit = bits_q[old_idx];

  always_comb begin
    bits_ev = bits_q;
    hit_ev  = hit_q;
    if (evict) begin
      // drop the oldest verdict
      bits_ev[old_idx] = 1'b0;
      if (old_bit && (hit_q != '0)) begin
        hit_ev = hit_q - CW'(1);
      end
    end
  end

  always_comb begin
    bits_d    = bits_q;
    fill_d    = fill_q;
    hit_d     = hit_q;
    latched_d = latched_q;
    if (ctrl_i.step && ctrl_i.clear) begin
      bits_d = '0;
      fill_d = '0;
      hit_d  = '0;
    end else if (push) begin
      bits_d = (bits_ev << 1) | MAX_WINDOW'(ctrl_i.green);
      fill_d = evict ? fill_q : fill_q + CW'(1);
      hit_d  = hit_ev + CW'(ctrl_i.green);
      if (WW'(hit_d) >= WW'(required_frames_i)) begin
        latched_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q    <= '0;
      fill_q    <= '0;
      hit_q     <= '0;
      latched_q <= 1'b0;
    end else begin
      bits_q    <= bits_d;
      fill_q    <= fill_d;
      hit_q     <= hit_d;
      latched_q <= latched_d;
    end
  end

  assign hit_q_o     = hit_q;
  assign green_d_o   = 6'(hit_d);
  assign latched_q_o = latched_q;
  assign latched_d_o = latched_d;

endmodule

`default_nettype wire

[sv/kwl_live.sv]
// Camera liveness: last usable frame time, seen flag, alive flag and timeout check.
`default_nettype none

module kwl_live (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire kwl_pkg::op_e op_i,
  input  wire logic        usable_i,
  input  wire logic [31:0] now_i,
  input  wire logic        latched_i,
  input  wire logic [31:0] timeout_i,
  output logic             alive_d_o,
  output logic             clear_o
);
  import kwl_pkg::*;

  logic        seen_q, seen_d;
  logic        alive_q, alive_d;
  logic [31:0] last_q, last_d;
  logic [31:0] age;

  assign age = now_i - last_q;

  always_comb begin
    seen_d  = seen_q;
    alive_d = alive_q;
    last_d  = last_q;
    clear_o = 1'b0;
    if (step_i) begin
      case (op_i)
        OP_FRAME: begin
          if (usable_i) begin
            seen_d  = 1'b1;
            last_d  = now_i;
            alive_d = 1'b1;
          end
        end
        OP_TICK: begin
          if (!latched_i) begin
            if (!seen_q) begin
              alive_d = 1'b0;
            end else if (now_i < last_q) begin
              // time went backwards: re-anchor
              last_d = now_i;
            end else if (age > timeout_i) begin
              alive_d = 1'b0;
              clear_o = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      alive_q <= 1'b0;
      last_q  <= '0;
    end else begin
      seen_q  <= seen_d;
      alive_q <= alive_d;
      last_q  <= last_d;
    end
  end

  assign alive_d_o = alive_d;

endmodule

`default_nettype wire
